@@ sv/caas_pkg.sv @@
// Shared types and constants for the bus address self-assignment block.
// Used by caas_gen and can_address_self_assignment; no dependencies.
package caas_pkg;

  localparam int ADDR_BITS   = 7;
  localparam int MAX_ADDRESS = 120;
  localparam int GUID_BYTES  = 16;
  localparam int ROT_BITS    = $clog2(ADDR_BITS);
  localparam int BYTE_BITS   = $clog2(GUID_BYTES);
  localparam int DELAY_BITS  = 10;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_TOKEN   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [1:0] TOK_OTHER   = 2'd0;
  localparam logic [1:0] TOK_REQUEST = 2'd1;
  localparam logic [1:0] TOK_IN_USE  = 2'd2;

  localparam logic SEND_REQUEST = 1'b0;
  localparam logic SEND_IN_USE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GUID0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUID1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GUID2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GUID3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ST_ADDR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ST_STAT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd7;

  localparam logic [127:0] GUID_RESET =
    {32'hA4A69FE5, 32'h9E957DBC, 32'h331CE9EC, 32'hEE4CAD97};
  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 10'd100;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    logic start;
    logic clear;
  } gen_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gen_stat_t;

  typedef struct packed {
    logic  status_timer_start;
    logic  address_static;
    logic  address_valid;
    addr_t node_address;
    addr_t send_value;
    logic  send_kind;
    logic  send_token;
  } result_t;

endpackage

@@ sv/caas_gen.sv @@
// Candidate address generator: one shared 7-bit adder summing GUID bytes
// XORed with the rotated seed, one byte per cycle, retrying until in range.
// Depends on caas_pkg.
module caas_gen (
  input  logic                     clk,
  input  logic                     rst_n,
  input  caas_pkg::gen_ctrl_t      ctrl_i,
  input  logic [127:0]             guid_i,
  input  caas_pkg::addr_t          seed_i,
  output caas_pkg::gen_stat_t      stat_o,
  output caas_pkg::addr_t          cand_o
);

  typedef enum logic [1:0] {
    G_IDLE = 2'b01,
    G_SUM  = 2'b10
  } gstate_t;

  gstate_t                            state_r, state_nxt;
  caas_pkg::addr_t                    acc_r, acc_nxt;
  caas_pkg::addr_t                    off_r, off_nxt;
  logic [caas_pkg::ROT_BITS-1:0]      rot_r, rot_nxt;
  logic [caas_pkg::BYTE_BITS-1:0]     byte_r, byte_nxt;
  caas_pkg::addr_t                    cand_r, cand_nxt;
  logic                               done_r, done_nxt;

  logic [2*caas_pkg::ADDR_BITS-1:0]   rot_dbl;
  caas_pkg::addr_t                    xval;
  logic [7:0]                         gbyte;
  caas_pkg::addr_t                    sum;
  logic                               in_range;

  always_comb begin
    rot_dbl  = {seed_i, seed_i} >> rot_r;
    xval     = rot_dbl[caas_pkg::ADDR_BITS-1:0];
    gbyte    = guid_i[{byte_r, 3'b000} +: 8];
    sum      = acc_r + (gbyte[caas_pkg::ADDR_BITS-1:0] ^ xval);
    in_range = (sum != '0) &&
               ({1'b0, sum} <= (caas_pkg::ADDR_BITS+1)'(caas_pkg::MAX_ADDRESS));
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    off_nxt   = off_r;
    rot_nxt   = rot_r;
    byte_nxt  = byte_r;
    cand_nxt  = cand_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      G_IDLE: begin
        if (ctrl_i.clear) begin
          off_nxt = '0;
          rot_nxt = '0;
        end else if (ctrl_i.start) begin
          acc_nxt   = off_r;
          byte_nxt  = '0;
          state_nxt = G_SUM;
        end
      end
      G_SUM: begin
        acc_nxt  = sum;
        byte_nxt = byte_r + 1'b1;
        if (byte_r == caas_pkg::BYTE_BITS'(caas_pkg::GUID_BYTES - 1)) begin
          if (rot_r == caas_pkg::ROT_BITS'(caas_pkg::ADDR_BITS - 1)) begin
            rot_nxt = '0;
            off_nxt = off_r + 1'b1;
          end else begin
            rot_nxt = rot_r + 1'b1;
          end
          acc_nxt = off_nxt;
          if (in_range) begin
            cand_nxt  = sum;
            done_nxt  = 1'b1;
            state_nxt = G_IDLE;
          end
        end
      end
      default: state_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      off_r   <= '0;
      rot_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      off_r   <= off_nxt;
      rot_r   <= rot_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    byte_r <= byte_nxt;
    cand_r <= cand_nxt;
  end

  assign stat_o.busy = (state_r == G_SUM);
  assign stat_o.done = done_r;
  assign cand_o      = cand_r;

endmodule

@@ sv/can_address_self_assignment.sv @@
// Bus node address self-assignment, top level: config registers, command
// sequencer, negotiation state and result register. Uses caas_pkg, caas_gen.
//
// Each item is a tick, a received token or a restart and yields one result.
// Restart, token and most ticks go through the result register and then the
// output register, where out_tready can hold them. A tick that must propose
// an address runs the generator: one GUID byte per cycle through a single
// adder per try, repeated until the candidate falls in 1..120, at most 7*128
// tries, then the result and output registers. No reset clearing pass.
module can_address_self_assignment (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,  // token_value, token_sender
  input  logic [3:0]                      in_tuser,  // command, token_kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // send_token, send_value, node_address, address_valid, address_static,
  // status_timer_start
  output logic [23:0]                     out_tdata,
  output logic                            out_tuser, // send_kind
  input  logic                            cfg_wr_en,
  input  logic [caas_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [caas_pkg::CFG_W-1:0]      cfg_wdata
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_GEN  = 3'b010,
    T_PUT  = 3'b100
  } tstate_t;

  logic [127:0]                        guid_r;
  caas_pkg::addr_t                     seed_r, st_addr_r;
  logic                                st_stat_r;
  logic [caas_pkg::DELAY_BITS-1:0]     delay_r;

  tstate_t                             state_r, state_nxt;
  caas_pkg::addr_t                     wa_r, wa_nxt;
  logic                                stat_r, stat_nxt;
  caas_pkg::addr_t                     prop_r, prop_nxt;
  logic [caas_pkg::DELAY_BITS-1:0]     cnt_r, cnt_nxt;
  caas_pkg::result_t                   res_r, res_nxt;
  logic                                ov_r, ov_nxt;
  caas_pkg::result_t                   od_r, od_nxt;

  caas_pkg::gen_ctrl_t                 gctrl;
  caas_pkg::gen_stat_t                 gstat;
  caas_pkg::addr_t                     gcand;

  logic [1:0]                          cmd, tkind;
  logic [15:0]                         tvalue;
  caas_pkg::addr_t                     tsender;
  logic                                accept, valid_now, valid_nxt;
  logic                                clash_use, clash_snd, out_free;

  function automatic logic addr_ok(caas_pkg::addr_t a, logic s);
    return ((a != '0) &&
            ({1'b0, a} <= (caas_pkg::ADDR_BITS+1)'(caas_pkg::MAX_ADDRESS))) || s;
  endfunction

  assign cmd     = in_tuser[1:0];
  assign tkind   = in_tuser[3:2];
  assign tvalue  = in_tdata[15:0];
  assign tsender = in_tdata[16 +: caas_pkg::ADDR_BITS];

  assign in_tready = (state_r == T_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !ov_r || out_tready;
  assign valid_now = addr_ok(wa_r, stat_r);

  caas_gen u_gen (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (gctrl),
    .guid_i (guid_r),
    .seed_i (seed_r),
    .stat_o (gstat),
    .cand_o (gcand)
  );

  always_comb begin
    clash_use = (tkind == caas_pkg::TOK_IN_USE) &&
                (tvalue == {{(16-caas_pkg::ADDR_BITS){1'b0}}, prop_r});
    clash_snd = (wa_r != '0) && (wa_r == tsender) && !stat_r;
  end

  always_comb begin
    state_nxt   = state_r;
    wa_nxt      = wa_r;
    stat_nxt    = stat_r;
    prop_nxt    = prop_r;
    cnt_nxt     = cnt_r;
    res_nxt     = res_r;
    ov_nxt      = ov_r && !out_tready;
    od_nxt      = od_r;
    gctrl.start = 1'b0;
    gctrl.clear = 1'b0;
    valid_nxt   = valid_now;
    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          res_nxt   = '0;
          state_nxt = T_PUT;
          unique case (cmd)
            caas_pkg::CMD_RESTART: begin
              wa_nxt      = st_addr_r;
              stat_nxt    = st_stat_r;
              prop_nxt    = '0;
              cnt_nxt     = '0;
              gctrl.clear = 1'b1;
              if (st_stat_r) begin
                res_nxt.send_token = 1'b1;
                res_nxt.send_kind  = caas_pkg::SEND_IN_USE;
                res_nxt.send_value = st_addr_r;
              end
            end
            caas_pkg::CMD_TICK: begin
              if (!valid_now) begin
                if (prop_r == '0) begin
                  gctrl.start = 1'b1;
                  state_nxt   = T_GEN;
                end else if (cnt_r <= caas_pkg::DELAY_BITS'(1)) begin
                  wa_nxt                     = prop_r;
                  prop_nxt                   = '0;
                  cnt_nxt                    = '0;
                  res_nxt.send_token         = 1'b1;
                  res_nxt.send_kind          = caas_pkg::SEND_IN_USE;
                  res_nxt.send_value         = prop_r;
                  res_nxt.status_timer_start = 1'b1;
                end else begin
                  cnt_nxt = cnt_r - 1'b1;
                end
              end
            end
            caas_pkg::CMD_TOKEN: begin
              if (clash_use || clash_snd) begin
                wa_nxt   = '0;
                prop_nxt = '0;
              end else if ((tkind == caas_pkg::TOK_REQUEST) &&
                           (tvalue == {{(16-caas_pkg::ADDR_BITS){1'b0}}, wa_r})) begin
                res_nxt.send_token = 1'b1;
                res_nxt.send_kind  = caas_pkg::SEND_IN_USE;
                res_nxt.send_value = wa_r;
              end
            end
            default: ;
          endcase
          valid_nxt              = addr_ok(wa_nxt, stat_nxt);
          res_nxt.node_address   = wa_nxt;
          res_nxt.address_valid  = valid_nxt;
          res_nxt.address_static = stat_nxt;
        end
      end
      T_GEN: begin
        if (gstat.done) begin
          prop_nxt           = gcand;
          cnt_nxt            = delay_r;
          res_nxt.send_token = 1'b1;
          res_nxt.send_kind  = caas_pkg::SEND_REQUEST;
          res_nxt.send_value = gcand;
          state_nxt          = T_PUT;
        end
      end
      T_PUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          od_nxt    = res_r;
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guid_r    <= caas_pkg::GUID_RESET;
      seed_r    <= '0;
      st_addr_r <= '0;
      st_stat_r <= 1'b0;
      delay_r   <= caas_pkg::DELAY_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        caas_pkg::REG_GUID0:   guid_r[31:0]   <= cfg_wdata;
        caas_pkg::REG_GUID1:   guid_r[63:32]  <= cfg_wdata;
        caas_pkg::REG_GUID2:   guid_r[95:64]  <= cfg_wdata;
        caas_pkg::REG_GUID3:   guid_r[127:96] <= cfg_wdata;
        caas_pkg::REG_SEED:    seed_r    <= cfg_wdata[caas_pkg::ADDR_BITS-1:0];
        caas_pkg::REG_ST_ADDR: st_addr_r <= cfg_wdata[caas_pkg::ADDR_BITS-1:0];
        caas_pkg::REG_ST_STAT: st_stat_r <= cfg_wdata[0];
        caas_pkg::REG_DELAY:   delay_r   <= cfg_wdata[caas_pkg::DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      wa_r    <= '0;
      stat_r  <= 1'b0;
      prop_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wa_r    <= wa_nxt;
      stat_r  <= stat_nxt;
      prop_r  <= prop_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    od_r  <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = od_r.send_kind;
  assign out_tdata  = {6'b0, od_r.status_timer_start, od_r.address_static,
                       od_r.address_valid, od_r.node_address, od_r.send_value,
                       od_r.send_token};

  a_gen_only_in_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (gstat.done || gstat.busy) |-> (state_r == T_GEN))
    else $error("generator active outside of generation state");

  a_cand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    gstat.done |-> ((gcand != '0) &&
      ({1'b0, gcand} <= (caas_pkg::ADDR_BITS+1)'(caas_pkg::MAX_ADDRESS))))
    else $error("generated candidate out of range");

  a_status_is_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && od_r.status_timer_start) |->
      (od_r.send_token && (od_r.send_kind == caas_pkg::SEND_IN_USE) && od_r.address_valid))
    else $error("adoption result without in-use announcement");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != T_IDLE))
    else $error("accepted item produced no pending result");

endmodule
